// ===== design/rnta_pkg.sv =====
// ----------------------------------------------------------------------------
// rnta_pkg
// Types, constants and the digit-to-ASCII mapping shared by the number to
// ASCII conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rnta_pkg;

  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int VALUE_W            = 64;
  localparam int RADIX_W            = 6;
  localparam int DIGIT_W            = 6;
  localparam int CHAR_W             = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET = 7'd55;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET = 7'd87;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic               lowercase;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] digit_code(input logic [DIGIT_W-1:0] d,
                                                    input logic lower);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DECIMAL_DIGITS) begin
      return d_ext + ASCII_ZERO;
    end else if (lower) begin
      return d_ext + LOWER_OFFSET;
    end else begin
      return d_ext + UPPER_OFFSET;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/rnta_ram.sv =====
// ----------------------------------------------------------------------------
// rnta_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rnta_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/radix_number_to_ascii_core.sv =====
// ----------------------------------------------------------------------------
// radix_number_to_ascii_core
// Renders an unsigned number as ASCII digits in a radix from 2 to 36, most
// significant digit first, one digit per output item.
// ----------------------------------------------------------------------------
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+----------------------
//   in      | input     | in_item_t   | in_valid / in_stall
//   out     | output    | out_item_t  | out_valid / out_stall
//
// Each digit comes from a bit-serial restoring divider that steps through
// all VALUE_BITS bits of the value. Digits are pushed into a small RAM stack
// least significant first and popped back in reverse order, each pop going
// through the S_READ and S_LOAD states. Reset clears only control state; the
// stack needs no clearing. A stall on the output holds the current item and
// pauses the pop.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_number_to_ascii_core
  import rnta_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW    = $clog2(VALUE_BITS);
  localparam int PTR_W = AW + 1;
  localparam int CNT_W = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOAD
  } state_t;

  state_t               state;
  logic [VALUE_BITS-1:0] val;
  logic [RADIX_W-1:0]   radix;
  logic                 lower;
  logic [DIGIT_W-1:0]   rem;
  logic [CNT_W-1:0]     cnt;
  logic [PTR_W-1:0]     ptr;
  logic                 qnz;

  logic [DIGIT_W:0]     trial;
  logic                 qbit;
  logic [DIGIT_W-1:0]   rem_next;
  logic [PTR_W-1:0]     ptr_dec;
  logic                 div_done;
  logic                 out_free;
  logic [RADIX_W-1:0]   radix_in;
  logic                 ram_we;
  logic [DIGIT_W-1:0]   ram_rdata;

  // One restoring division step: bring in the next dividend bit and subtract
  // the radix when the partial remainder allows it.
  always_comb begin
    trial    = {rem, val[VALUE_BITS-1]};
    qbit     = (trial >= {1'b0, radix});
    rem_next = qbit ? DIGIT_W'(trial - {1'b0, radix}) : DIGIT_W'(trial);
    ptr_dec  = ptr - 1'b1;
    div_done = (state == S_DIV) && (cnt == CNT_W'(VALUE_BITS - 1));
    ram_we   = div_done;
    out_free = !out_valid || !out_stall;
    if (in_data.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_data.radix;
    end
  end

  assign in_stall = (state != S_IDLE);

  rnta_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ptr[AW-1:0]),
    .wdata(rem_next),
    .raddr(ptr_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      ptr       <= '0;
      qnz       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            val   <= in_data.value[VALUE_BITS-1:0];
            radix <= radix_in;
            lower <= in_data.lowercase;
            rem   <= '0;
            cnt   <= '0;
            ptr   <= '0;
            qnz   <= 1'b0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          val <= {val[VALUE_BITS-2:0], qbit};
          if (div_done) begin
            // The remainder is pushed; the quotient left in val is the next
            // dividend unless it is zero.
            ptr <= ptr + 1'b1;
            rem <= '0;
            cnt <= '0;
            qnz <= 1'b0;
            if (!(qnz || qbit)) begin
              state <= S_READ;
            end
          end else begin
            rem <= rem_next;
            cnt <= cnt + 1'b1;
            qnz <= qnz || qbit;
          end
        end
        S_READ: begin
          if (out_free) begin
            ptr   <= ptr_dec;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          out_valid          <= 1'b1;
          out_data.character <= digit_code(ram_rdata, lower);
          out_data.last      <= (ptr == '0);
          state              <= (ptr == '0) ? S_IDLE : S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rnta_checker.sv =====
// ----------------------------------------------------------------------------
// rnta_checker
// Port-level checks on the number to ASCII conversion block, bound to
// radix_number_to_ascii_core.
// ----------------------------------------------------------------------------
`default_nettype none

module rnta_checker
  import rnta_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled output item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  // Once an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // No digit can appear in the cycle right after an item is taken.
  a_no_early_digit: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("digit appeared too early after an accepted item");

  // While a digit that is not the final one is shown, the item is unfinished.
  a_busy_mid_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> in_stall)
    else $error("input open while a number is still being emitted");

endmodule

bind radix_number_to_ascii_core rnta_checker u_rnta_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for radix_number_to_ascii_core. A table of fixed
// numbers (zero, all ones, clamped radixes, letter digits) runs first, then
// random numbers of mixed length in every radix. Each accepted number is
// spelled out by its table text or a local predictor, and the digits that
// come back are compared one by one. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
  import rnta_pkg::*;

  localparam int VALUE_BITS = 64;
  localparam logic [63:0] VALUE_MASK = ~64'd0 >> (64 - VALUE_BITS);
  localparam logic [CHAR_W-1:0] CH_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'd65;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'd97;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_GAP     = 8;

  typedef struct {
    logic [63:0]        value;
    logic [RADIX_W-1:0] radix;
    logic               lowercase;
    string              text;
  } number_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  out_item_t   pending_digits[$];
  string       typed_text_q[$];
  int unsigned mismatch_count;
  bit          gaps_on;
  bit          long_hold_req;

  // An empty text means the row is checked against the predictor.
  number_row_t number_rows [24] = '{
    '{64'd0, 6'd10, 1'b0, "0"},
    '{64'd0, 6'd2, 1'b0, "0"},
    '{64'd0, 6'd36, 1'b1, "0"},
    '{64'd1, 6'd2, 1'b0, "1"},
    '{~64'd0, 6'd16, 1'b0, "FFFFFFFFFFFFFFFF"},
    '{~64'd0, 6'd16, 1'b1, "ffffffffffffffff"},
    '{~64'd0, 6'd10, 1'b0, "18446744073709551615"},
    '{~64'd0, 6'd2, 1'b0, ""},
    '{~64'd0, 6'd36, 1'b1, ""},
    '{64'd35, 6'd36, 1'b0, "Z"},
    '{64'd35, 6'd36, 1'b1, "z"},
    '{64'd10, 6'd11, 1'b1, "a"},
    '{64'd9, 6'd10, 1'b0, "9"},
    '{64'd10, 6'd10, 1'b0, "10"},
    '{64'd5, 6'd0, 1'b0, "101"},
    '{64'd6, 6'd1, 1'b0, "110"},
    '{64'd36, 6'd37, 1'b0, "10"},
    '{64'd35, 6'd63, 1'b1, "z"},
    '{64'd255, 6'd8, 1'b0, "377"},
    '{64'h8000_0000_0000_0000, 6'd2, 1'b1, ""},
    '{64'd123456789, 6'd36, 1'b0, ""},
    '{64'h8000_0000_0000_0000, 6'd3, 1'b0, ""},
    '{~64'd0, 6'd63, 1'b0, ""},
    '{64'h0123_4567_89AB_CDEF, 6'd16, 1'b1, "123456789abcdef"}
  };

  radix_number_to_ascii_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 50) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Queues the digit stream that one number should produce.
  function automatic void spell_number(input in_item_t item);
    logic [63:0]        num;
    logic [63:0]        base;
    logic [DIGIT_W-1:0] digs [64];
    logic [CHAR_W-1:0]  code;
    int                 n;
    out_item_t          ch;
    num  = item.value & VALUE_MASK;
    base = 64'(item.radix);
    if (base < 64'd2) begin
      base = 64'd2;
    end else if (base > 64'd36) begin
      base = 64'd36;
    end
    n = 0;
    if (num == 64'd0) begin
      digs[0] = '0;
      n = 1;
    end
    while (num != 64'd0) begin
      digs[n] = DIGIT_W'(num % base);
      num = num / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (digs[k] < 10) begin
        code = CH_ZERO + CHAR_W'(digs[k]);
      end else if (item.lowercase) begin
        code = CH_LOWER_A + CHAR_W'(digs[k] - 10);
      end else begin
        code = CH_UPPER_A + CHAR_W'(digs[k] - 10);
      end
      ch.character = code;
      ch.last      = (k == 0);
      pending_digits.push_back(ch);
    end
  endfunction

  task automatic send_number(input in_item_t item, input string text);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    typed_text_q.push_back(text);
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Mostly short numbers so that the bit-serial divider stays quick; a few
  // use the full width.
  task automatic run_random(input int count);
    in_item_t    item;
    int unsigned pick;
    int unsigned width;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        width = 0;
      end else if (pick < 70) begin
        width = $urandom_range(20, 1);
      end else if (pick < 90) begin
        width = $urandom_range(48, 21);
      end else begin
        width = $urandom_range(64, 49);
      end
      item.value = {$urandom, $urandom};
      if (width == 0) begin
        item.value = '0;
      end else if (width < 64) begin
        item.value = item.value & ((64'd1 << width) - 64'd1);
      end
      if ($urandom_range(99, 0) < 85) begin
        item.radix = RADIX_W'($urandom_range(36, 2));
      end else begin
        item.radix = RADIX_W'($urandom_range(63, 0));
      end
      item.lowercase = 1'($urandom_range(1, 0));
      send_number(item, "");
    end
  endtask

  task automatic wait_drained();
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : scoreboard
    string     text;
    out_item_t want;
    byte       c;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        text = typed_text_q.pop_front();
        if (text.len() == 0) begin
          spell_number(in_data);
        end else begin
          for (int i = 0; i < text.len(); i++) begin
            c = text[i];
            want.character = c[6:0];
            want.last      = (i == text.len() - 1);
            pending_digits.push_back(want);
          end
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_digits.size() == 0) begin
          flag_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                  out_data.character, out_data.last));
        end else begin
          want = pending_digits.pop_front();
          if (out_data.character !== want.character) begin
            flag_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                    out_data.character, want.character));
          end
          if (out_data.last !== want.last) begin
            flag_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                    out_data.last, want.last, want.character));
          end
        end
      end
    end
  end

  initial begin : receiver
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** radix_number_to_ascii_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    in_item_t item;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    long_hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (number_rows[i]) begin
      item.value     = number_rows[i].value;
      item.radix     = number_rows[i].radix;
      item.lowercase = number_rows[i].lowercase;
      send_number(item, number_rows[i].text);
    end

    run_random(120);
    gaps_on = 1'b0;
    run_random(60);

    // The receiver holds off while short numbers keep arriving, so the
    // block backs up and stalls its input.
    long_hold_req = 1'b1;
    repeat (16) begin
      item.value     = 64'($urandom_range(999, 0));
      item.radix     = RADIX_W'($urandom_range(36, 2));
      item.lowercase = 1'($urandom_range(1, 0));
      send_number(item, "");
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    gaps_on = 1'b1;
    run_random(150);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digits.size() != 0) begin
      flag_mismatch($sformatf("%0d characters never arrived", pending_digits.size()));
    end
    if (mismatch_count == 0) begin
      $display("** radix_number_to_ascii_core: PASSED **");
    end else begin
      $display("** radix_number_to_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule
